// File: design/pct_pkg.sv
`timescale 1ns / 1ps

package pct_pkg;

  localparam logic [1:0] MODE_ESCAPE_ALL  = 2'd0;
  localparam logic [1:0] MODE_KEEP_SLASH  = 2'd1;
  localparam logic [1:0] MODE_UNESCAPE    = 2'd2;

  localparam logic [1:0] PHASE_IDLE = 2'd0;
  localparam logic [1:0] PHASE_HIGH = 2'd1;
  localparam logic [1:0] PHASE_LOW  = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_TRUNC   = 2'd1;
  localparam logic [1:0] STATUS_BAD_HEX = 2'd2;

  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_TILDE   = 8'h7E;

  localparam logic [1:0] STEP_PERCENT = 2'd0;
  localparam logic [1:0] STEP_HIGH    = 2'd1;
  localparam logic [1:0] STEP_LOW     = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_data;
    logic       expand;
    logic       eos;
    logic [1:0] status;
  } job_t;

  function automatic logic is_unreserved(input logic [7:0] b, input logic keep_slash);
    logic r;
    r = 1'b0;
    if (b >= 8'h61 && b <= 8'h7A) r = 1'b1;
    if (b >= 8'h41 && b <= 8'h5A) r = 1'b1;
    if (b >= 8'h30 && b <= 8'h39) r = 1'b1;
    if (b == 8'h2D || b == 8'h2E || b == 8'h5F || b == CHAR_TILDE) r = 1'b1;
    if (keep_slash && b == CHAR_SLASH) r = 1'b1;
    return r;
  endfunction

  // Bit 4 set means the byte is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] v;
    v = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = {1'b0, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      v = 5'd9 + {2'b00, b[2:0]};
    end
    return v;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = {4'h3, nib};
    end else begin
      c = 8'h37 + {4'h0, nib};
    end
    return c;
  endfunction

endpackage

// File: design/percent_codec.sv
`timescale 1ns / 1ps

// Channel   Direction  tdata                      tuser       tlast
// in_       slave      [7:0] in_byte              -           last
// out_      master     [7:0] out_byte, [9:8] st   byte_valid  end_of_string
// cfg_      write      [1:0] codec_mode           -           -
//
// Decoding and pass-through bytes flow at one transaction per cycle while out_tready stays high.
// An escaped byte leaves the output as '%' and two hex digits, stepped out by the output sequencer.
// Input is taken while the job queue has room; results wait in the output register.
// Reset is synchronous and active low and clears the mode, the codec state and the queue.

module percent_codec #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [9:8] status, [15:10] zero
  output logic        out_tuser,  // [0] byte_valid
  output logic        out_tlast,
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_wdata
);

  localparam int LW = $clog2(QUEUE_DEPTH) + 1;

  logic [1:0]    codec_mode_r;
  logic          accept;
  logic          push;
  pct_pkg::job_t push_job;
  logic          pop;
  logic          head_valid;
  pct_pkg::job_t head_job;
  logic [LW-1:0] level;
  logic [7:0]    out_byte;
  logic [1:0]    out_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codec_mode_r <= pct_pkg::MODE_ESCAPE_ALL;
    end else if (cfg_wen) begin
      codec_mode_r <= cfg_wdata;
    end
  end

  assign in_tready = (level != LW'(QUEUE_DEPTH));
  assign accept    = in_tvalid && in_tready;

  pct_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .mode    (codec_mode_r),
    .push    (push),
    .job     (push_job)
  );

  pct_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job),
    .level      (level)
  );

  pct_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head_job       (head_job),
    .pop            (pop),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_byte       (out_byte),
    .out_byte_valid (out_tuser),
    .out_eos        (out_tlast),
    .out_status     (out_status)
  );

  assign out_tdata = {6'b000000, out_status, out_byte};

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level <= LW'(QUEUE_DEPTH))
    else $error("job queue level exceeds its depth");

  a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_status == pct_pkg::STATUS_OK))
    else $error("nonzero status on a result that does not end the string");

  a_status_only_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tlast && out_byte == 8'h00))
    else $error("status-only result is malformed");

  a_escape_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast && $past(codec_mode_r) != pct_pkg::MODE_UNESCAPE
     && codec_mode_r != pct_pkg::MODE_UNESCAPE && $stable(codec_mode_r)
     && out_tuser && out_byte == pct_pkg::CHAR_PERCENT) |-> (out_status == pct_pkg::STATUS_OK))
    else $error("escape mode produced an error status");

endmodule

// File: design/pct_front.sv
`timescale 1ns / 1ps

module pct_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  input  logic [1:0]       mode,
  output logic             push,
  output pct_pkg::job_t    job
);

  logic [1:0] escape_phase_r, escape_phase_nxt;
  logic [3:0] high_nibble_r, high_nibble_nxt;
  logic [1:0] error_kind_r, error_kind_nxt;
  logic [4:0] hv;
  logic       bad;
  logic       has_data;
  logic [7:0] data_byte;
  logic [1:0] status;

  always_comb begin
    hv               = pct_pkg::hex_value(in_byte);
    bad              = hv[4];
    escape_phase_nxt = escape_phase_r;
    high_nibble_nxt  = high_nibble_r;
    error_kind_nxt   = error_kind_r;
    has_data         = 1'b0;
    data_byte        = in_byte;
    status           = pct_pkg::STATUS_OK;
    job              = '0;

    if (mode != pct_pkg::MODE_UNESCAPE) begin
      has_data   = 1'b1;
      job.expand = !pct_pkg::is_unreserved(in_byte, mode == pct_pkg::MODE_KEEP_SLASH);
    end else begin
      priority if (escape_phase_r == pct_pkg::PHASE_HIGH) begin
        if (bad) begin
          error_kind_nxt = pct_pkg::STATUS_BAD_HEX;
        end else begin
          high_nibble_nxt = hv[3:0];
        end
        escape_phase_nxt = pct_pkg::PHASE_LOW;
      end else if (escape_phase_r == pct_pkg::PHASE_LOW) begin
        if (bad) begin
          error_kind_nxt = pct_pkg::STATUS_BAD_HEX;
        end else if (error_kind_r == pct_pkg::STATUS_OK) begin
          has_data  = 1'b1;
          data_byte = {high_nibble_r, hv[3:0]};
        end
        escape_phase_nxt = pct_pkg::PHASE_IDLE;
      end else begin
        escape_phase_nxt = pct_pkg::PHASE_IDLE;
        if (in_byte == pct_pkg::CHAR_PERCENT) begin
          escape_phase_nxt = pct_pkg::PHASE_HIGH;
        end else if (error_kind_r == pct_pkg::STATUS_OK) begin
          has_data = 1'b1;
        end
      end
      status = (escape_phase_nxt != pct_pkg::PHASE_IDLE) ? pct_pkg::STATUS_TRUNC
                                                         : error_kind_nxt;
    end

    if (in_last) begin
      escape_phase_nxt = pct_pkg::PHASE_IDLE;
      high_nibble_nxt  = 4'h0;
      error_kind_nxt   = pct_pkg::STATUS_OK;
    end

    job.data_byte = has_data ? data_byte : 8'h00;
    job.has_data  = has_data;
    job.eos       = in_last;
    job.status    = in_last ? status : pct_pkg::STATUS_OK;
    push          = accept && (has_data || in_last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_phase_r <= pct_pkg::PHASE_IDLE;
      high_nibble_r  <= 4'h0;
      error_kind_r   <= pct_pkg::STATUS_OK;
    end else if (accept) begin
      escape_phase_r <= escape_phase_nxt;
      high_nibble_r  <= high_nibble_nxt;
      error_kind_r   <= error_kind_nxt;
    end
  end

endmodule

// File: design/pct_queue.sv
`timescale 1ns / 1ps

module pct_queue #(
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  pct_pkg::job_t              push_job,
  input  logic                       pop,
  output logic                       head_valid,
  output pct_pkg::job_t              head_job,
  output logic [$clog2(DEPTH):0]     level
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  pct_pkg::job_t   mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]     level_r, level_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      level_nxt = level_r + 1'b1;
    end else if (pop && !push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  assign head_valid = (level_r != '0);
  assign head_job   = mem[rd_ptr_r];
  assign level      = level_r;

endmodule

// File: design/pct_back.sv
`timescale 1ns / 1ps

module pct_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  pct_pkg::job_t head_job,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_byte_valid,
  output logic          out_eos,
  output logic [1:0]    out_status
);

  logic [1:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       byte_valid_r, byte_valid_nxt;
  logic       eos_r, eos_nxt;
  logic [1:0] status_r, status_nxt;
  logic       load;
  logic       final_step;

  always_comb begin
    load           = head_valid && (!out_valid_r || out_ready);
    final_step     = !head_job.expand || (step_r == pct_pkg::STEP_LOW);
    pop            = load && final_step;
    step_nxt       = step_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_byte_nxt   = out_byte_r;
    byte_valid_nxt = byte_valid_r;
    eos_nxt        = eos_r;
    status_nxt     = status_r;
    if (load) begin
      out_valid_nxt  = 1'b1;
      step_nxt       = final_step ? pct_pkg::STEP_PERCENT : step_r + 2'd1;
      byte_valid_nxt = head_job.has_data;
      eos_nxt        = head_job.eos && final_step;
      status_nxt     = (head_job.eos && final_step) ? head_job.status : pct_pkg::STATUS_OK;
      if (!head_job.expand) begin
        out_byte_nxt = head_job.data_byte;
      end else begin
        unique case (step_r)
          pct_pkg::STEP_PERCENT: out_byte_nxt = pct_pkg::CHAR_PERCENT;
          pct_pkg::STEP_HIGH:    out_byte_nxt = pct_pkg::hex_char(head_job.data_byte[7:4]);
          default:               out_byte_nxt = pct_pkg::hex_char(head_job.data_byte[3:0]);
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= pct_pkg::STEP_PERCENT;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r   <= out_byte_nxt;
    byte_valid_r <= byte_valid_nxt;
    eos_r        <= eos_nxt;
    status_r     <= status_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_byte_valid = byte_valid_r;
  assign out_eos        = eos_r;
  assign out_status     = status_r;

endmodule
